[src/itcf_pkg.sv]
// Shared types, constants and lookup functions of the IMU tilt filter.
// No dependencies; every other file but itcf_ifs imports this package.
package itcf_pkg;

	localparam int DVD_W     = 48;  // divider dividend and quotient width
	localparam int DVS_W     = 18;  // divider divisor width
	localparam int XW        = 28;  // CORDIC x/y width
	localparam int STW       = 36;  // gyro angle step width
	localparam int SW        = 5;   // controller step counter width
	localparam int SQRT_STEPS = 24; // one result bit per step, two radicand bits per step over 48 bits

	localparam logic [2:0] REG_GYRO_RANGE   = 3'd0;
	localparam logic [2:0] REG_ACCEL_RANGE  = 3'd1;
	localparam logic [2:0] REG_UP_AXIS      = 3'd2;
	localparam logic [2:0] REG_CALIB_COUNT  = 3'd3;
	localparam logic [2:0] REG_BLEND_WEIGHT = 3'd4;

	localparam logic [1:0]  RST_GYRO_RANGE   = 2'd0;
	localparam logic [1:0]  RST_ACCEL_RANGE  = 2'd2;
	localparam logic [1:0]  RST_UP_AXIS      = 2'd3;
	localparam logic [10:0] RST_CALIB_COUNT  = 11'd200;
	localparam logic [16:0] RST_BLEND_WEIGHT = 17'd58982;

	localparam logic [1:0] UP_NONE = 2'd0;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_ACCUM, OP_CDIV_ST, OP_CDIV_END, OP_UPG, OP_CORR,
		OP_SQ0, OP_SQ1, OP_SQRT, OP_CORI, OP_CORDIC, OP_TEND, OP_GMUL,
		OP_GDIV_ST, OP_GDIV_END, OP_BL0, OP_BL1, OP_BL2, OP_BL3, OP_ZINT, OP_OUT
	} op_t;

	typedef struct packed {
		op_t           op;
		logic [2:0]    idx;
		logic [SW-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic calib;
		logic calib_last;
		logic div_done;
	} sts_t;

	typedef struct packed {
		logic [1:0]  gyro_range;
		logic [1:0]  accel_range;
		logic [1:0]  up_axis;
		logic [10:0] calib_count;
		logic [16:0] blend_weight;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] acc_x;
		logic signed [15:0] acc_y;
		logic signed [15:0] acc_z;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
		logic [15:0]        elapsed_ms;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] angle_x;
		logic signed [31:0] angle_y;
		logic signed [31:0] angle_z;
	} res_t;

	// atan(2^-i) in Q16 degrees
	function automatic logic signed [31:0] atan_q16(input logic [4:0] i);
		logic signed [31:0] r;
		unique case (i)
			5'd0:  r = 32'sd2949120;
			5'd1:  r = 32'sd1740967;
			5'd2:  r = 32'sd919879;
			5'd3:  r = 32'sd466945;
			5'd4:  r = 32'sd234379;
			5'd5:  r = 32'sd117304;
			5'd6:  r = 32'sd58666;
			5'd7:  r = 32'sd29335;
			5'd8:  r = 32'sd14668;
			5'd9:  r = 32'sd7334;
			5'd10: r = 32'sd3667;
			5'd11: r = 32'sd1833;
			5'd12: r = 32'sd917;
			5'd13: r = 32'sd458;
			5'd14: r = 32'sd229;
			5'd15: r = 32'sd115;
			5'd16: r = 32'sd57;
			5'd17: r = 32'sd29;
			5'd18: r = 32'sd14;
			5'd19: r = 32'sd7;
			5'd20: r = 32'sd4;
			5'd21: r = 32'sd2;
			5'd22: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	// gyro LSB per deg/s in tenths, times 100
	function automatic logic [DVS_W-1:0] gyro_den(input logic [1:0] rng);
		logic [DVS_W-1:0] r;
		unique case (rng)
			2'd0: r = 18'd131000;
			2'd1: r = 18'd65500;
			2'd2: r = 18'd32800;
			2'd3: r = 18'd16400;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] one_g(input logic [1:0] rng);
		return 16'd16384 >> rng;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
		logic signed [31:0] r;
		if (v > 56'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -56'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[src/itcf_ifs.sv]
// Valid/ready channel interfaces for the sample and result items.
// Payload widths are written out here; itcf_pkg is not imported.
interface itcf_samp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] acc_x;
	logic signed [15:0] acc_y;
	logic signed [15:0] acc_z;
	logic signed [15:0] rate_x;
	logic signed [15:0] rate_y;
	logic signed [15:0] rate_z;
	logic [15:0]        elapsed_ms;
	modport source (output valid, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, elapsed_ms,
		input ready);
	modport sink (input valid, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, elapsed_ms,
		output ready);
endinterface

interface itcf_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] angle_x;
	logic signed [31:0] angle_y;
	logic signed [31:0] angle_z;
	modport source (output valid, angle_x, angle_y, angle_z, input ready);
	modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

[src/itcf_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on itcf_pkg for operand widths.
module itcf_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [itcf_pkg::DVD_W-1:0] dvd,
	input  logic [itcf_pkg::DVS_W-1:0] dvs,
	output logic                      done,
	output logic [itcf_pkg::DVD_W-1:0] quo
);
	import itcf_pkg::*;

	localparam int CW = $clog2(DVD_W);

	logic             busy_q, done_q;
	logic [CW-1:0]    cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q, dvs_q;
	logic [DVS_W:0]   trial, diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = ge ? trial - {1'b0, dvs_q} : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dvd;
			rem_q <= '0;
			dvs_q <= dvs;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= diff[DVS_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[src/itcf_dp.sv]
// Datapath: calibration sums and offsets, square root, CORDIC, gyro step and blend.
// Depends on itcf_pkg and itcf_div; driven by commands from itcf_ctrl.
module itcf_dp #(
	parameter int MAX_CALIB_SAMPLES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  itcf_pkg::cmd_t    cmd,
	input  itcf_pkg::cfg_t    cfg,
	input  itcf_pkg::sample_t samp,
	output itcf_pkg::sts_t    sts,
	output itcf_pkg::res_t    res
);
	import itcf_pkg::*;

	localparam int SUMW = 17 + $clog2(MAX_CALIB_SAMPLES);
	localparam int CNTW = $clog2(MAX_CALIB_SAMPLES + 1);

	logic signed [15:0]     raw_q  [6];
	logic signed [15:0]     corr_q [6];
	logic signed [15:0]     off_q  [6];
	logic signed [SUMW-1:0] sum_q  [6];
	logic signed [31:0]     ang_q  [3];
	logic signed [STW-1:0]  stp_q  [3];
	logic signed [31:0]     tilt_q [2];
	logic [15:0]            ms_q;
	logic [CNTW-1:0]        seen_q;
	logic [31:0]            p_q, prod_q;
	logic [DVD_W-1:0]       sv_q, sr_q;
	logic signed [XW-1:0]   x_q, y_q;
	logic signed [31:0]     z_q;
	logic                   zero_q;
	logic signed [36:0]     g_q;
	logic signed [54:0]     m1_q;
	logic signed [49:0]     m2_q;
	res_t                   out_q;

	logic [31:0]            need;
	logic [2:0]             gi;
	logic [1:0]             ai;
	logic signed [SUMW-1:0] ssel;
	logic [SUMW-1:0]        smag;
	logic signed [31:0]     u32, v32, usq, vsq;
	logic [31:0]            sqsum;
	logic [5:0]             bsh;
	logic [DVD_W-1:0]       bval, rb;
	logic signed [16:0]     num17;
	logic signed [XW-1:0]   numx, xs, ys;
	logic signed [31:0]     tz;
	logic signed [15:0]     gc;
	logic [15:0]            gmag;
	logic [16:0]            w;
	logic signed [17:0]     ws, wr;
	logic signed [55:0]     tsum, zsum56;
	logic signed [36:0]     zsum;
	logic                   div_start, div_done;
	logic [DVD_W-1:0]       div_dvd, div_quo;
	logic [DVS_W-1:0]       div_dvs;
	logic [15:0]            q16;

	// sample count that finishes calibration
	always_comb begin
		if (cfg.calib_count == '0) begin
			need = 32'd1;
		end else if (32'(cfg.calib_count) > 32'(MAX_CALIB_SAMPLES)) begin
			need = 32'(MAX_CALIB_SAMPLES);
		end else begin
			need = 32'(cfg.calib_count);
		end
	end

	assign sts.calib      = 32'(seen_q) < need;
	assign sts.calib_last = (32'(seen_q) + 32'd1) == need;
	assign sts.div_done   = div_done;

	always_comb begin
		gi    = 3'd3 + cmd.idx;
		ai    = cmd.idx[1:0];
		ssel  = sum_q[cmd.idx];
		smag  = ssel[SUMW-1] ? SUMW'(-ssel) : SUMW'(ssel);
		u32   = cmd.idx[0] ? 32'(corr_q[1]) : 32'(corr_q[0]);
		v32   = 32'(corr_q[2]);
		usq   = u32 * u32;
		vsq   = v32 * v32;
		sqsum = p_q + 32'(vsq);
		bsh   = 6'd46 - {cmd.step, 1'b0};
		bval  = DVD_W'(1) << bsh;
		rb    = sr_q + bval;
		num17 = cmd.idx[0] ? -17'(corr_q[0]) : 17'(corr_q[1]);
		numx  = XW'(num17);
		xs    = x_q >>> cmd.step;
		ys    = y_q >>> cmd.step;
		tz    = zero_q ? 32'sd0 : z_q;
		gc    = corr_q[gi];
		gmag  = gc[15] ? 16'(-gc) : 16'(gc);
		w     = (cfg.blend_weight > 17'd65536) ? 17'd65536 : cfg.blend_weight;
		ws    = 18'(w);
		wr    = 18'(18'd65536 - 18'(w));
		tsum  = 56'(m1_q) + 56'(m2_q) + 56'sd32768;
		zsum  = 37'(ang_q[2]) + 37'(stp_q[2]);
		zsum56 = 56'(zsum);
		q16   = div_quo[15:0];
	end

	always_comb begin
		div_start = (cmd.op == OP_CDIV_ST) || (cmd.op == OP_GDIV_ST);
		if (cmd.op == OP_CDIV_ST) begin
			div_dvd = DVD_W'(smag);
			div_dvs = DVS_W'(seen_q);
		end else begin
			div_dvd = {prod_q, 16'h0000} + DVD_W'(gyro_den(cfg.gyro_range) >> 1);
			div_dvs = gyro_den(cfg.gyro_range);
		end
	end

	itcf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (div_dvd),
		.dvs    (div_dvs),
		.done   (div_done),
		.quo    (div_quo)
	);

	// filter state: sums, offsets, sample count and angles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				sum_q[i] <= '0;
				off_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				ang_q[i] <= '0;
			end
			seen_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_ACCUM: begin
					for (int i = 0; i < 6; i++) begin
						sum_q[i] <= sum_q[i] + SUMW'(raw_q[i]);
					end
					seen_q <= seen_q + 1'b1;
				end
				OP_CDIV_END: off_q[cmd.idx] <= ssel[SUMW-1] ? -q16 : q16;
				OP_UPG: begin
					if (cfg.up_axis != UP_NONE) begin
						off_q[3'(cfg.up_axis - 2'd1)] <=
							off_q[3'(cfg.up_axis - 2'd1)] - one_g(cfg.accel_range);
					end
				end
				OP_BL3:  ang_q[ai] <= sat32(tsum >>> 16);
				OP_ZINT: ang_q[2] <= sat32(zsum56);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				raw_q[0] <= samp.acc_x;
				raw_q[1] <= samp.acc_y;
				raw_q[2] <= samp.acc_z;
				raw_q[3] <= samp.rate_x;
				raw_q[4] <= samp.rate_y;
				raw_q[5] <= samp.rate_z;
				ms_q     <= samp.elapsed_ms;
			end
			OP_CORR: begin
				for (int i = 0; i < 6; i++) begin
					corr_q[i] <= raw_q[i] - off_q[i];
				end
			end
			OP_SQ0: p_q <= 32'(usq);
			OP_SQ1: begin
				sv_q <= {sqsum, 16'h0000};
				sr_q <= '0;
			end
			OP_SQRT: begin
				if (sv_q >= rb) begin
					sv_q <= sv_q - rb;
					sr_q <= (sr_q >> 1) + bval;
				end else begin
					sr_q <= sr_q >> 1;
				end
			end
			OP_CORI: begin
				x_q    <= XW'(sr_q);
				y_q    <= numx <<< 8;
				z_q    <= '0;
				zero_q <= (sr_q == '0) && (num17 == '0);
			end
			OP_CORDIC: begin
				// y == 0 rotates the negative way
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_q16(5'(cmd.step));
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_q16(5'(cmd.step));
				end
			end
			OP_TEND: begin
				if (cmd.idx[0]) begin
					tilt_q[1] <= tz;
				end else begin
					tilt_q[0] <= -tz;
				end
			end
			OP_GMUL: prod_q <= 32'(gmag) * 32'(ms_q);
			OP_GDIV_END: stp_q[ai] <= gc[15] ? -STW'(div_quo) : STW'(div_quo);
			OP_BL0: g_q  <= 37'(ang_q[ai]) + 37'(stp_q[ai]);
			OP_BL1: m1_q <= g_q * ws;
			OP_BL2: m2_q <= tilt_q[cmd.idx[0]] * wr;
			OP_OUT: begin
				out_q.angle_x <= ang_q[0];
				out_q.angle_y <= ang_q[1];
				out_q.angle_z <= ang_q[2];
			end
			default: begin
			end
		endcase
	end

	assign res = out_q;

endmodule

[src/itcf_ctrl.sv]
// Controller: sequences calibration, tilt, gyro and blend steps per item.
// Depends on itcf_pkg; drives itcf_dp through cmd_t and reads sts_t.
module itcf_ctrl #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           out_ready,
	input  itcf_pkg::sts_t sts,
	output itcf_pkg::cmd_t cmd,
	output logic           in_ready,
	output logic           out_valid
);
	import itcf_pkg::*;

	typedef enum logic [19:0] {
		S_IDLE    = 20'h00001,
		S_BRANCH  = 20'h00002,
		S_CDIV_ST = 20'h00004,
		S_CDIV_WT = 20'h00008,
		S_UPG     = 20'h00010,
		S_SQ0     = 20'h00020,
		S_SQ1     = 20'h00040,
		S_SQRT    = 20'h00080,
		S_CORI    = 20'h00100,
		S_COR     = 20'h00200,
		S_TEND    = 20'h00400,
		S_GMUL    = 20'h00800,
		S_GST     = 20'h01000,
		S_GWT     = 20'h02000,
		S_BL0     = 20'h04000,
		S_BL1     = 20'h08000,
		S_BL2     = 20'h10000,
		S_BL3     = 20'h20000,
		S_ZINT    = 20'h40000,
		S_OUT     = 20'h80000
	} state_t;

	state_t        state_q, state_d;
	logic [SW-1:0] cnt_q, cnt_d;
	logic [2:0]    idx_q, idx_d;
	logic          outv_q, in_fire, out_free;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !outv_q || out_ready;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		cmd.op   = OP_NONE;
		cmd.idx  = idx_q;
		cmd.step = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.op  = OP_LOAD;
					state_d = S_BRANCH;
				end
			end
			S_BRANCH: begin
				idx_d = '0;
				cnt_d = '0;
				if (sts.calib) begin
					cmd.op  = OP_ACCUM;
					state_d = sts.calib_last ? S_CDIV_ST : S_IDLE;
				end else begin
					cmd.op  = OP_CORR;
					state_d = S_SQ0;
				end
			end
			S_CDIV_ST: begin
				cmd.op  = OP_CDIV_ST;
				state_d = S_CDIV_WT;
			end
			S_CDIV_WT: begin
				if (sts.div_done) begin
					cmd.op = OP_CDIV_END;
					if (idx_q == 3'd5) begin
						state_d = S_UPG;
					end else begin
						idx_d   = idx_q + 3'd1;
						state_d = S_CDIV_ST;
					end
				end
			end
			S_UPG: begin
				cmd.op  = OP_UPG;
				state_d = S_IDLE;
			end
			S_SQ0: begin
				cmd.op  = OP_SQ0;
				state_d = S_SQ1;
			end
			S_SQ1: begin
				cmd.op  = OP_SQ1;
				cnt_d   = '0;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = OP_SQRT;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == SW'(SQRT_STEPS - 1)) begin
					state_d = S_CORI;
				end
			end
			S_CORI: begin
				cmd.op  = OP_CORI;
				cnt_d   = '0;
				state_d = S_COR;
			end
			S_COR: begin
				cmd.op = OP_CORDIC;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == SW'(CORDIC_STEPS - 1)) begin
					state_d = S_TEND;
				end
			end
			S_TEND: begin
				cmd.op = OP_TEND;
				if (idx_q == 3'd0) begin
					idx_d   = 3'd1;
					state_d = S_SQ0;
				end else begin
					idx_d   = 3'd0;
					state_d = S_GMUL;
				end
			end
			S_GMUL: begin
				cmd.op  = OP_GMUL;
				state_d = S_GST;
			end
			S_GST: begin
				cmd.op  = OP_GDIV_ST;
				state_d = S_GWT;
			end
			S_GWT: begin
				if (sts.div_done) begin
					cmd.op = OP_GDIV_END;
					if (idx_q == 3'd2) begin
						idx_d   = 3'd0;
						state_d = S_BL0;
					end else begin
						idx_d   = idx_q + 3'd1;
						state_d = S_GMUL;
					end
				end
			end
			S_BL0: begin
				cmd.op  = OP_BL0;
				state_d = S_BL1;
			end
			S_BL1: begin
				cmd.op  = OP_BL1;
				state_d = S_BL2;
			end
			S_BL2: begin
				cmd.op  = OP_BL2;
				state_d = S_BL3;
			end
			S_BL3: begin
				cmd.op = OP_BL3;
				if (idx_q == 3'd1) begin
					state_d = S_ZINT;
				end else begin
					idx_d   = 3'd1;
					state_d = S_BL0;
				end
			end
			S_ZINT: begin
				cmd.op  = OP_ZINT;
				state_d = S_OUT;
			end
			S_OUT: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			outv_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			if (cmd.op == OP_OUT) begin
				outv_q <= 1'b1;
			end else if (out_ready) begin
				outv_q <= 1'b0;
			end
		end
	end

	assign out_valid = outv_q;

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == S_CDIV_WT || state_q == S_GWT))
		else $error("divider finished outside a wait state");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |-> out_free)
		else $error("result overwritten before it was taken");

	a_fire_branch: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_BRANCH)
		else $error("accepted item not dispatched");

	a_out_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |=> outv_q)
		else $error("result valid not raised");

endmodule

[src/imu_tilt_complementary_filter.sv]
// Top level of the IMU tilt complementary filter: APB register file,
// controller and datapath. Depends on itcf_pkg, itcf_ifs, itcf_ctrl, itcf_dp.
//
// Usage: raw sensor items enter on samp (valid/ready); filtered angles leave
// on res (valid/ready). Registers sit on the APB port at byte address 4*i:
// gyro_range, accel_range, up_axis, calib_count, blend_weight. Write them
// only while the block is idle.
// The first calib_count items (at least one, at most MAX_CALIB_SAMPLES) are
// summed and give no result; the last of them starts a six-way offset division.
// Every later item gives one result: two square roots of 24 steps, two CORDIC
// runs of CORDIC_STEPS steps and three gyro divisions on the shared bit-serial
// divider. One item is in work at a time; samp.ready is high only when the
// controller is idle.
// A finished result sits in an output register; the next item is accepted
// and worked on while it waits, and is held at the end until res is taken.
// Reset (arst_n low) restores register defaults, clears sums, offsets,
// the sample count and the angles, and drops res.valid.
module imu_tilt_complementary_filter #(
	parameter int MAX_CALIB_SAMPLES = 1024,
	parameter int CORDIC_STEPS      = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	itcf_samp_if.sink   samp,
	itcf_res_if.source  res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import itcf_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd;
	sts_t    sts;
	sample_t samp_d;
	res_t    res_d;
	logic    wr_en;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign ridx   = paddr[4:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gyro_range   <= RST_GYRO_RANGE;
			cfg_q.accel_range  <= RST_ACCEL_RANGE;
			cfg_q.up_axis      <= RST_UP_AXIS;
			cfg_q.calib_count  <= RST_CALIB_COUNT;
			cfg_q.blend_weight <= RST_BLEND_WEIGHT;
		end else if (wr_en) begin
			unique case (ridx)
				REG_GYRO_RANGE:   cfg_q.gyro_range   <= pwdata[1:0];
				REG_ACCEL_RANGE:  cfg_q.accel_range  <= pwdata[1:0];
				REG_UP_AXIS:      cfg_q.up_axis      <= pwdata[1:0];
				REG_CALIB_COUNT:  cfg_q.calib_count  <= pwdata[10:0];
				REG_BLEND_WEIGHT: cfg_q.blend_weight <= pwdata[16:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_GYRO_RANGE:   prdata = 32'(cfg_q.gyro_range);
			REG_ACCEL_RANGE:  prdata = 32'(cfg_q.accel_range);
			REG_UP_AXIS:      prdata = 32'(cfg_q.up_axis);
			REG_CALIB_COUNT:  prdata = 32'(cfg_q.calib_count);
			REG_BLEND_WEIGHT: prdata = 32'(cfg_q.blend_weight);
			default:          prdata = '0;
		endcase
	end

	assign samp_d.acc_x      = samp.acc_x;
	assign samp_d.acc_y      = samp.acc_y;
	assign samp_d.acc_z      = samp.acc_z;
	assign samp_d.rate_x     = samp.rate_x;
	assign samp_d.rate_y     = samp.rate_y;
	assign samp_d.rate_z     = samp.rate_z;
	assign samp_d.elapsed_ms = samp.elapsed_ms;

	itcf_ctrl #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samp.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (samp.ready),
		.out_valid (res.valid)
	);

	itcf_dp #(
		.MAX_CALIB_SAMPLES (MAX_CALIB_SAMPLES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.samp   (samp_d),
		.sts    (sts),
		.res    (res_d)
	);

	assign res.angle_x = res_d.angle_x;
	assign res.angle_y = res_d.angle_y;
	assign res.angle_z = res_d.angle_z;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the IMU tilt complementary filter.
// Depends on itcf_pkg, itcf_ifs and the filter RTL; predicts angles in SV.
`timescale 1ns / 100ps

module tb_top;
	import itcf_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	itcf_samp_if samp ();
	itcf_res_if  res ();

	imu_tilt_complementary_filter dut (
		.clk(clk), .arst_n(arst_n), .samp(samp.sink), .res(res.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [1:0]       m_gyro_range, m_accel_range, m_up_axis;
	logic [10:0]      m_calib_count;
	logic [16:0]      m_blend_weight;
	longint           m_sums[6];
	logic signed [15:0] m_offs[6];
	int               m_seen;
	logic signed [31:0] m_ang[3];

	res_t   angle_queue[$];
	int     errors;
	int     send_idle_pct, recv_stall_pct;

	const longint ATAN_TAB[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
		58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

	initial begin
		clk = 1'b0;
		forever begin
			#6 clk = 1'b1;
			#6 clk = 1'b0;
		end
	end

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint sat_i32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint tilt_angle(longint num, longint unsigned sq);
		longint x, y, z, xs, ys;
		x = int_sqrt(sq << 16);
		y = num * 256;
		z = 0;
		if (x == 0 && y == 0) return 0;
		for (int i = 0; i < 16; i++) begin
			xs = asr(x, i);
			ys = asr(y, i);
			if (y > 0) begin
				x += ys; y -= xs; z += ATAN_TAB[i];
			end else begin
				x -= ys; y += xs; z -= ATAN_TAB[i];
			end
		end
		return z;
	endfunction

	function automatic longint rate_step(longint c, longint ms);
		longint unsigned mag, den, q;
		mag = (c < 0) ? -c : c;
		case (m_gyro_range)
			2'd0: den = 131000;
			2'd1: den = 65500;
			2'd2: den = 32800;
			default: den = 16400;
		endcase
		q = (mag * ms * 65536 + den / 2) / den;
		return (c < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint mix_angle(longint prev, longint stp, longint tilt, longint w);
		longint t;
		t = (prev + stp) * w + tilt * (65536 - w);
		return sat_i32(asr(t + 32768, 16));
	endfunction

	function automatic int calib_target();
		int n;
		n = m_calib_count;
		if (n == 0) n = 1;
		if (n > 1024) n = 1024;
		return n;
	endfunction

	// update predictor for one sample; push an expected angle set if one comes out
	function automatic void predict_angles(sample_t s);
		logic signed [15:0] raw[6], c[6];
		longint ax, ay, az, tx, ty, w;
		logic [15:0] o;
		res_t r;
		raw = '{s.acc_x, s.acc_y, s.acc_z, s.rate_x, s.rate_y, s.rate_z};
		if (m_seen < calib_target()) begin
			for (int i = 0; i < 6; i++) m_sums[i] += raw[i];
			m_seen++;
			if (m_seen == calib_target()) begin
				for (int i = 0; i < 6; i++) m_offs[i] = 16'(m_sums[i] / m_seen);
				if (m_up_axis != UP_NONE) begin
					o = m_offs[m_up_axis - 1] - (16'd16384 >> m_accel_range);
					m_offs[m_up_axis - 1] = o;
				end
			end
			return;
		end
		for (int i = 0; i < 6; i++) c[i] = raw[i] - m_offs[i];
		ax = c[0]; ay = c[1]; az = c[2];
		w = (m_blend_weight > 65536) ? 65536 : m_blend_weight;
		tx = -tilt_angle(ay, ax * ax + az * az);
		ty = tilt_angle(-ax, ay * ay + az * az);
		m_ang[0] = mix_angle(m_ang[0], rate_step(c[3], s.elapsed_ms), tx, w);
		m_ang[1] = mix_angle(m_ang[1], rate_step(c[4], s.elapsed_ms), ty, w);
		m_ang[2] = sat_i32(longint'(m_ang[2]) + rate_step(c[5], s.elapsed_ms));
		r.angle_x = m_ang[0];
		r.angle_y = m_ang[1];
		r.angle_z = m_ang[2];
		angle_queue.push_back(r);
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
		paddr = {idx, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		case (idx)
			REG_GYRO_RANGE:   m_gyro_range = val[1:0];
			REG_ACCEL_RANGE:  m_accel_range = val[1:0];
			REG_UP_AXIS:      m_up_axis = val[1:0];
			REG_CALIB_COUNT:  m_calib_count = val[10:0];
			REG_BLEND_WEIGHT: m_blend_weight = val[16:0];
			default: ;
		endcase
	endtask

	task automatic send_sample(sample_t s);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		samp.valid = 1'b1;
		samp.acc_x = s.acc_x; samp.acc_y = s.acc_y; samp.acc_z = s.acc_z;
		samp.rate_x = s.rate_x; samp.rate_y = s.rate_y; samp.rate_z = s.rate_z;
		samp.elapsed_ms = s.elapsed_ms;
		@(posedge clk);
		while (!samp.ready) @(posedge clk);
		predict_angles(s);
		@(negedge clk);
		samp.valid = 1'b0;
	endtask

	// wait for every expected item, then let an in-flight calibration sample finish
	task automatic drain();
		while (angle_queue.size() != 0) @(negedge clk);
		repeat (600) @(negedge clk);
	endtask

	function automatic sample_t rand_sample(int spread);
		sample_t s;
		s.acc_x = $urandom_range(spread) - spread / 2;
		s.acc_y = $urandom_range(spread) - spread / 2;
		s.acc_z = $urandom_range(spread) - spread / 2;
		s.rate_x = $urandom_range(spread) - spread / 2;
		s.rate_y = $urandom_range(spread) - spread / 2;
		s.rate_z = $urandom_range(spread) - spread / 2;
		s.elapsed_ms = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(200));
		return s;
	endfunction

	function automatic sample_t full_sample();
		sample_t s;
		s = {$urandom, $urandom, $urandom, $urandom};
		return s;
	endfunction

	// receiver: stall at random, compare each item with the oldest expectation
	initial begin
		res_t exp_r;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			res.ready = ($urandom_range(99) >= recv_stall_pct);
			@(posedge clk);
			if (res.valid && res.ready) begin
				if (angle_queue.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected item x=%0d y=%0d z=%0d",
						res.angle_x, res.angle_y, res.angle_z);
				end else begin
					exp_r = angle_queue.pop_front();
					if (exp_r.angle_x !== res.angle_x || exp_r.angle_y !== res.angle_y ||
						exp_r.angle_z !== res.angle_z) begin
						errors++;
						if (errors <= 10)
							$display("mismatch exp %0d %0d %0d got %0d %0d %0d",
								exp_r.angle_x, exp_r.angle_y, exp_r.angle_z,
								res.angle_x, res.angle_y, res.angle_z);
					end
				end
			end
		end
	end

	task automatic test_directed();
		sample_t s;
		write_reg(REG_CALIB_COUNT, 2);
		write_reg(REG_UP_AXIS, 3);
		s = '{16'sd10, -16'sd20, 16'sd4100, 16'sd5, -16'sd3, 16'sd1, 16'd10};
		send_sample(s);
		send_sample(s);
		// zero elapsed time, horizontal term zero, extremes of every field
		send_sample('{16'sd10, -16'sd20, 16'sd4096, 16'sd5, -16'sd3, 16'sd1, 16'd0});
		send_sample('{16'sd10, 16'sd100, 16'sd4096, 16'sd5, -16'sd3, 16'sd1, 16'd100});
		send_sample('{16'sd10, -16'sd20, 16'sd4196, 16'sd5, -16'sd3, 16'sd1, 16'd100});
		send_sample('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff});
		send_sample('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff});
		send_sample('{16'h8000, 16'h7fff, 16'h0, 16'h8000, 16'h7fff, 16'h8000, 16'hffff});
		for (int i = 0; i < 6; i++) send_sample(full_sample());
		drain();
		// raise count after calibration: calibration resumes
		write_reg(REG_CALIB_COUNT, 5);
		for (int i = 0; i < 6; i++) send_sample(full_sample());
		drain();
		// count lowered to zero after calibration, blend weight above the maximum, unused register
		write_reg(REG_CALIB_COUNT, 0);
		write_reg(REG_BLEND_WEIGHT, 17'h1ffff);
		write_reg(3'd7, 32'hffff_ffff);
		for (int i = 0; i < 4; i++) send_sample(full_sample());
		drain();
	endtask

	task automatic test_random_phase(int n, int spread);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2) drain();
			send_sample(($urandom_range(9) == 0) ? full_sample() : rand_sample(spread));
		end
		drain();
	endtask

	task automatic test_config_sweep();
		write_reg(REG_GYRO_RANGE, 3);
		write_reg(REG_ACCEL_RANGE, 0);
		write_reg(REG_UP_AXIS, 0);
		write_reg(REG_BLEND_WEIGHT, 0);
		write_reg(REG_CALIB_COUNT, 11'd1030);
		send_idle_pct = 0; recv_stall_pct = 0;
		test_random_phase(1100, 4000);
		write_reg(REG_GYRO_RANGE, 1);
		write_reg(REG_ACCEL_RANGE, 3);
		write_reg(REG_UP_AXIS, 1);
		write_reg(REG_BLEND_WEIGHT, 65536);
		write_reg(REG_CALIB_COUNT, 1040);
		send_idle_pct = 20; recv_stall_pct = 57;
		test_random_phase(120, 65535);
		write_reg(REG_GYRO_RANGE, 2);
		write_reg(REG_ACCEL_RANGE, 1);
		write_reg(REG_UP_AXIS, 2);
		write_reg(REG_BLEND_WEIGHT, $urandom_range(65536));
		send_idle_pct = 57; recv_stall_pct = 20;
		test_random_phase(120, 20000);
	endtask

	initial begin
		errors = 0;
		send_idle_pct = 20; recv_stall_pct = 57;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		samp.valid = 1'b0;
		samp.acc_x = '0; samp.acc_y = '0; samp.acc_z = '0;
		samp.rate_x = '0; samp.rate_y = '0; samp.rate_z = '0; samp.elapsed_ms = '0;
		m_gyro_range = RST_GYRO_RANGE; m_accel_range = RST_ACCEL_RANGE;
		m_up_axis = RST_UP_AXIS; m_calib_count = RST_CALIB_COUNT;
		m_blend_weight = RST_BLEND_WEIGHT;
		for (int i = 0; i < 6; i++) begin
			m_sums[i] = 0; m_offs[i] = 0;
		end
		m_seen = 0;
		for (int i = 0; i < 3; i++) m_ang[i] = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_config_sweep();
		if (errors == 0 && angle_queue.size() == 0) begin
			$display("imu_tilt_complementary_filter test passed");
		end else begin
			$display("imu_tilt_complementary_filter test failed");
		end
		$finish;
	end

	initial begin
		#12ms;
		$display("imu_tilt_complementary_filter test failed");
		$finish;
	end

endmodule

[imu_tilt_complementary_filter.f]
src/itcf_pkg.sv
src/itcf_ifs.sv
src/itcf_div.sv
src/itcf_dp.sv
src/itcf_ctrl.sv
src/imu_tilt_complementary_filter.sv
tb/sv/tb_top.sv
